FILE: hdl/cicd_pkg.sv
// cicd_pkg: shared constants and types for the cic5 decimator
// no dependencies; imported by every module of the block
`default_nettype none

package cicd_pkg;

  localparam int FILTER_ORDER = 5;
  localparam int MAX_FACTOR   = 64;
  localparam int SAMPLE_W     = 32;
  localparam int ACC_W        = 64;
  localparam int FACTOR_W     = 7;
  localparam int SHIFT_W      = 6;
  localparam int PHASE_W      = 7;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int APB_AW       = 3;

  localparam logic [SAMPLE_W-1:0] SAT_LIMIT = 32'hFFFF_FFFF;

  // register index taken from paddr[2]
  localparam logic REG_FACTOR = 1'b0;
  localparam logic REG_SHIFT  = 1'b1;

  // comb history slot
  localparam logic SLOT_FIRST  = 1'b0;
  localparam logic SLOT_SECOND = 1'b1;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [SHIFT_W-1:0]  shift;
  } cicd_cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             slot;
  } cicd_entry_t;

  typedef struct packed {
    logic push;
    logic push_ready;
    logic pop;
    logic empty;
  } cicd_queue_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/cic5_decimator_shift_saturate.sv
// cic5_decimator_shift_saturate: top level, apb registers and front/queue/back
// one sample per cycle while sample_stall is low; a result passes the integrator stages, the queue,
// the comb stages and the output register; throughput: 1 item/cycle through the integrator chain
// while it is not held, set by one 64-bit add per stage; input stalls only when the 4-entry queue is full
// and the output is held; synchronous reset zeroes integrators, comb history and phase; factor 1, shift 0
`default_nettype none

module cic5_decimator_shift_saturate
  import cicd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                block_end,
  output logic                     filtered_valid,
  input  wire logic                filtered_stall,
  output logic [SAMPLE_W-1:0]      filtered
);

  cicd_cfg_t       cfg;
  cicd_entry_t     push_entry;
  cicd_entry_t     head;
  logic            push;
  logic            push_ready;
  logic            pop;
  logic            empty;
  logic            wr_en;
  logic            unused_block_end;

  // buffer marker carries no filtering meaning
  assign unused_block_end = block_end;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.factor <= FACTOR_W'(1);
      cfg.shift  <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_FACTOR: cfg.factor <= pwdata[FACTOR_W-1:0];
        REG_SHIFT:  cfg.shift  <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FACTOR: prdata = {{(32-FACTOR_W){1'b0}}, cfg.factor};
      REG_SHIFT:  prdata = {{(32-SHIFT_W){1'b0}}, cfg.shift};
      default:    prdata = '0;
    endcase
  end

  cicd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .push_ready   (push_ready),
    .push         (push),
    .push_entry   (push_entry)
  );

  cicd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  cicd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .filtered_valid (filtered_valid),
    .filtered_stall (filtered_stall),
    .filtered       (filtered)
  );

endmodule

`default_nettype wire

FILE: hdl/cicd_front.sv
// cicd_front: integrator pipeline and phase counter, one stage per integrator
// depends on cicd_pkg; feeds firing items into the queue
`default_nettype none

module cicd_front
  import cicd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cicd_cfg_t           cfg,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                push_ready,
  output logic                     push,
  output cicd_entry_t              push_entry
);

  logic [ACC_W-1:0]   int_sum [FILTER_ORDER];
  logic               stage_v [FILTER_ORDER];
  logic               stage_fire [FILTER_ORDER];
  logic               stage_slot [FILTER_ORDER];
  logic [PHASE_W-1:0] phase;

  logic                adv;
  logic                take;
  logic [FACTOR_W-1:0] eff_factor;
  logic [PHASE_W:0]    phase_inc;
  logic [PHASE_W:0]    twice_factor;
  logic                fire_now;
  logic                slot_now;
  logic [PHASE_W-1:0]  phase_next;

  always_comb begin
    if (cfg.factor == '0) begin
      eff_factor = FACTOR_W'(1);
    end else if (cfg.factor > FACTOR_W'(MAX_FACTOR)) begin
      eff_factor = FACTOR_W'(MAX_FACTOR);
    end else begin
      eff_factor = cfg.factor;
    end
  end

  always_comb begin
    phase_inc    = {1'b0, phase} + (PHASE_W+1)'(1);
    twice_factor = {eff_factor, 1'b0};
    fire_now     = 1'b0;
    slot_now     = SLOT_FIRST;
    phase_next   = phase_inc[PHASE_W-1:0];
    if (phase_inc >= twice_factor) begin
      // also catches a phase left past the cycle by a lowered factor
      fire_now   = 1'b1;
      slot_now   = SLOT_SECOND;
      phase_next = '0;
    end else if (phase_inc == {1'b0, eff_factor}) begin
      fire_now = 1'b1;
    end
  end

  // the pipeline only holds when a firing item meets a full queue
  assign adv          = !(stage_v[FILTER_ORDER-1] && stage_fire[FILTER_ORDER-1] && !push_ready);
  assign sample_stall = !adv;
  assign take         = sample_valid && adv;

  assign push             = adv && stage_v[FILTER_ORDER-1] && stage_fire[FILTER_ORDER-1];
  assign push_entry.value = int_sum[FILTER_ORDER-1];
  assign push_entry.slot  = stage_slot[FILTER_ORDER-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      for (int k = 0; k < FILTER_ORDER; k++) begin
        int_sum[k] <= '0;
        stage_v[k] <= 1'b0;
      end
    end else if (adv) begin
      stage_v[0] <= sample_valid;
      if (take) begin
        int_sum[0]    <= int_sum[0] + ACC_W'(sample);
        stage_fire[0] <= fire_now;
        stage_slot[0] <= slot_now;
        phase         <= phase_next;
      end
      // stage k adds the sum held in the register of stage k-1
      for (int k = 1; k < FILTER_ORDER; k++) begin
        stage_v[k] <= stage_v[k-1];
        if (stage_v[k-1]) begin
          int_sum[k]    <= int_sum[k] + int_sum[k-1];
          stage_fire[k] <= stage_fire[k-1];
          stage_slot[k] <= stage_slot[k-1];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cicd_queue.sv
// cicd_queue: short fifo of firing items between front and back
// depends on cicd_pkg
`default_nettype none

module cicd_queue
  import cicd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire cicd_entry_t push_entry,
  output logic             push_ready,
  input  wire logic        pop,
  output logic             empty,
  output cicd_entry_t      head
);

  cicd_entry_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] count_next;
  logic               full;

  assign full       = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty      = (count == '0);
  assign push_ready = !full || pop;
  assign head       = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + FIFO_CW'(1);
    end else if (pop && !push) begin
      count_next = count - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cicd_back.sv
// cicd_back: comb pipeline with ping-pong history, shift, saturate, output register
// depends on cicd_pkg; drains the queue
`default_nettype none

module cicd_back
  import cicd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cicd_cfg_t           cfg,
  input  wire logic                empty,
  input  wire cicd_entry_t         head,
  output logic                     pop,
  output logic                     filtered_valid,
  input  wire logic                filtered_stall,
  output logic [SAMPLE_W-1:0]      filtered
);

  logic [ACC_W-1:0] hist [FILTER_ORDER][2];
  logic [ACC_W-1:0] c_val [FILTER_ORDER];
  logic             c_v [FILTER_ORDER];
  logic             c_slot [FILTER_ORDER];

  logic [ACC_W-1:0] in_val [FILTER_ORDER];
  logic             in_v [FILTER_ORDER];
  logic             in_slot [FILTER_ORDER];

  logic             b_adv;
  logic [ACC_W-1:0] shifted;
  logic [SAMPLE_W-1:0] sat_val;

  assign b_adv = !filtered_valid || !filtered_stall;
  assign pop   = b_adv && !empty;

  always_comb begin
    in_val[0]  = head.value;
    in_v[0]    = !empty;
    in_slot[0] = head.slot;
    for (int k = 1; k < FILTER_ORDER; k++) begin
      in_val[k]  = c_val[k-1];
      in_v[k]    = c_v[k-1];
      in_slot[k] = c_slot[k-1];
    end
  end

  assign shifted = c_val[FILTER_ORDER-1] >> cfg.shift;
  assign sat_val = (shifted[ACC_W-1:SAMPLE_W] != '0) ? SAT_LIMIT : shifted[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_valid <= 1'b0;
      for (int k = 0; k < FILTER_ORDER; k++) begin
        c_v[k]     <= 1'b0;
        hist[k][0] <= '0;
        hist[k][1] <= '0;
      end
    end else if (b_adv) begin
      filtered_valid <= c_v[FILTER_ORDER-1];
      for (int k = 0; k < FILTER_ORDER; k++) begin
        c_v[k] <= in_v[k];
        if (in_v[k]) begin
          c_val[k]              <= in_val[k] - hist[k][in_slot[k]];
          hist[k][in_slot[k]]   <= in_val[k];
          c_slot[k]             <= in_slot[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && c_v[FILTER_ORDER-1]) begin
      filtered <= sat_val;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cicd_checker.sv
// cicd_checker: port-level assertions for the cic5 decimator
// depends on cicd_pkg; bound to cic5_decimator_shift_saturate
`default_nettype none

module cicd_checker
  import cicd_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                sample_valid,
  input wire logic                sample_stall,
  input wire logic                filtered_valid,
  input wire logic                filtered_stall,
  input wire logic [SAMPLE_W-1:0] filtered
);

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !filtered_valid)
    else $error("result valid after reset");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    filtered_valid && filtered_stall |=> filtered_valid && $stable(filtered))
    else $error("held result changed");

  // the input only backs up when the output side is holding
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> filtered_valid && filtered_stall)
    else $error("input stalled while output flows");

  // a stalled input item stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid)
    else $error("stalled input item withdrawn");

endmodule

bind cic5_decimator_shift_saturate cicd_checker u_cicd_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_stall   (sample_stall),
  .filtered_valid (filtered_valid),
  .filtered_stall (filtered_stall),
  .filtered       (filtered)
);

`default_nettype wire
